/* src/pli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants
// Command and result payloads, status and operation codes, saturation helpers.
// ----------------------------------------------------------------------------
package pli_pkg;

    // table depth; point_index and segment_index are sized for it
    localparam int MAX_POINTS = 64;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
    localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

    typedef struct packed {
        logic               operation;
        logic [5:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] y_value;
        logic [5:0]         segment_index;
        logic [1:0]         status;
    } t_result;

    function automatic logic is_sat32(input logic signed [64:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/piecewise_linear_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with interpolated lookup
// Loads breakpoints, binary-searches segments, caches slope and intercept.
// ----------------------------------------------------------------------------
// Usage:
//   Commands go in on i_cmd with start; a transfer happens when start is high
//   and busy is low. Each command yields one result on o_result, marked by
//   o_result_valid for exactly one cycle; the receiver cannot stall it.
//   A load leaves busy low, so commands can follow at once.
//   A query walks the binary search through the x table memory, a read and a
//   compare per halving, then fetches both segment ends and checks the cache.
//   On a cache hit a multiply and a scale-add follow. On a miss a zero-width
//   segment gives a zero-status result; otherwise the slope divider runs
//   (Q16.16 by default), then the intercept multiply. busy is high for the
//   whole query.
//   points_in_use is written through the i_cfg channel, always ready; write
//   it only while the block is idle.
//   Reset clears the segment valid bits and sets points_in_use to 2; the
//   table memories are undefined until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pli_pkg::t_cmd     i_cmd,
    output logic              o_result_valid,
    output pli_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);

    localparam int MAX_POINTS = pli_pkg::MAX_POINTS;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_FL   = 4'd3;
    localparam logic [3:0] S_FR   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_MULB = 4'd7;
    localparam logic [3:0] S_BFIN = 4'd8;
    localparam logic [3:0] S_MULY = 4'd9;
    localparam logic [3:0] S_YFIN = 4'd10;

    logic [3:0]             r_state, n_state;
    logic [6:0]             r_points;
    logic [MAX_POINTS-1:0]  r_valid;
    logic                   r_strobe, n_strobe;
    pli_pkg::t_result       r_result, n_result;

    logic [IW-1:0]          r_left, r_right;
    logic signed [31:0]     r_q;
    logic signed [31:0]     r_xl, r_yl, r_kc, r_bc, r_xr, r_yr;
    logic signed [31:0]     r_k, r_b;
    logic signed [63:0]     r_prod;

    logic signed [31:0]     x_mem [MAX_POINTS];
    logic signed [31:0]     y_mem [MAX_POINTS];
    logic signed [31:0]     k_mem [MAX_POINTS];
    logic signed [31:0]     b_mem [MAX_POINTS];
    logic signed [31:0]     r_x_rd, r_y_rd, r_k_rd, r_b_rd;
    logic [IW-1:0]          rd_addr;

    logic                   accept;
    logic                   is_load;
    logic                   load_in_range;
    logic [IW-1:0]          load_addr;
    logic [NW-1:0]          n_pts;
    logic [IW:0]            mid_sum;
    logic [IW-1:0]          mid;
    logic                   span_open;
    logic signed [32:0]     dx, dy;
    logic                   div_start, div_done;
    logic signed [31:0]     div_k;
    logic signed [31:0]     mul_b;
    logic signed [63:0]     prod_adj, scaled;
    logic signed [64:0]     b_full, y_full;
    logic [31:0]            left32;

    assign accept        = start && !busy;
    assign is_load       = i_cmd.operation == pli_pkg::OP_LOAD;
    assign load_in_range = 32'(i_cmd.point_index) < MAX_POINTS;
    assign load_addr     = IW'(32'(i_cmd.point_index));
    assign n_pts         = (32'(r_points) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_points);
    assign mid_sum       = {1'b0, r_left} + {1'b0, r_right};
    assign mid           = mid_sum[IW:1];
    assign span_open     = {1'b0, r_right} > ({1'b0, r_left} + 1'b1);
    assign dx            = 33'(r_xr) - 33'(r_xl);
    assign dy            = 33'(r_yr) - 33'(r_yl);
    assign left32        = 32'(r_left);

    // shared multiplier: intercept term, then the output term
    assign mul_b    = (r_state == S_MULB) ? r_xl : r_q;
    // divide by 2^FRAC_BITS, truncating toward zero
    assign prod_adj = r_prod + (r_prod[63] ? 64'sd2 ** FRAC_BITS - 64'sd1 : 64'sd0);
    assign scaled   = prod_adj >>> FRAC_BITS;
    assign b_full   = 65'(r_yl) - 65'(scaled);
    assign y_full   = 65'(scaled) + 65'(r_b);

    assign busy           = r_state != S_IDLE;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_strobe;
    assign o_result       = r_result;

    pli_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dy    (dy),
        .i_dx    (dx),
        .o_done  (div_done),
        .o_k     (div_k)
    );

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_result  = r_result;
        div_start = 1'b0;
        rd_addr   = r_left;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_load) begin
                        n_strobe = 1'b1;
                        n_result = '{y_value: '0, segment_index: i_cmd.point_index,
                                     status: pli_pkg::ST_LOAD};
                    end else if (n_pts < NW'(2)) begin
                        n_strobe = 1'b1;
                        n_result = '{y_value: '0, segment_index: '0,
                                     status: pli_pkg::ST_ZERO};
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (span_open) begin
                    rd_addr = mid;
                    n_state = S_SCMP;
                end else begin
                    n_state = S_FL;
                end
            end
            S_SCMP: n_state = S_SRCH;
            S_FL: begin
                rd_addr = r_right;
                n_state = S_FR;
            end
            S_FR: n_state = S_CHK;
            S_CHK: begin
                if (r_valid[r_left]) begin
                    n_state = S_MULY;
                end else if (dx == 33'sd0) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_result = '{y_value: r_yl, segment_index: left32[5:0],
                                 status: pli_pkg::ST_ZERO};
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MULB;
                end
            end
            S_MULB: n_state = S_BFIN;
            S_BFIN: n_state = S_MULY;
            S_MULY: n_state = S_YFIN;
            S_YFIN: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_result = '{y_value: pli_pkg::sat32(y_full), segment_index: left32[5:0],
                             status: pli_pkg::is_sat32(y_full) ? pli_pkg::ST_SAT
                                                               : pli_pkg::ST_OK};
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_points <= 7'd2;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_points <= i_cfg_data;
            end
            if (accept && is_load && load_in_range) begin
                r_valid[load_addr] <= 1'b0;
                if (load_addr != '0) begin
                    r_valid[load_addr - 1'b1] <= 1'b0;
                end
            end
            if (r_state == S_BFIN) begin
                r_valid[r_left] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        case (r_state)
            S_IDLE: begin
                r_q     <= i_cmd.query_x;
                r_left  <= '0;
                r_right <= IW'(n_pts - 1'b1);
            end
            S_SCMP: begin
                if (r_x_rd > r_q) begin
                    r_right <= mid;
                end else begin
                    r_left <= mid;
                end
            end
            S_FL: begin
                r_xl <= r_x_rd;
                r_yl <= r_y_rd;
                r_kc <= r_k_rd;
                r_bc <= r_b_rd;
            end
            S_FR: begin
                r_xr <= r_x_rd;
                r_yr <= r_y_rd;
            end
            S_CHK: begin
                r_k <= r_kc;
                r_b <= r_bc;
            end
            S_DIV: begin
                if (div_done) begin
                    r_k <= div_k;
                end
            end
            S_MULB, S_MULY: r_prod <= r_k * mul_b;
            S_BFIN: r_b <= pli_pkg::sat32(b_full);
            default: ;
        endcase
    end

    // table and cache memories
    always_ff @(posedge i_clk) begin
        if (accept && is_load && load_in_range) begin
            x_mem[load_addr] <= i_cmd.point_x;
            y_mem[load_addr] <= i_cmd.point_y;
        end
        if (r_state == S_BFIN) begin
            k_mem[r_left] <= r_k;
            b_mem[r_left] <= pli_pkg::sat32(b_full);
        end
        r_x_rd <= x_mem[rd_addr];
        r_y_rd <= y_mem[rd_addr];
        r_k_rd <= k_mem[rd_addr];
        r_b_rd <= b_mem[rd_addr];
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == S_IDLE)
        else $error("result strobe while a query is in flight");

    a_div_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> !span_open)
        else $error("divider running before the search closed");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

endmodule

/* src/pli_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_div: segment slope divider
// Radix-2 restoring division k = dy * 2^FRAC_BITS / dx, one quotient bit per
// cycle, truncated toward zero and saturated to 32 signed bits.
// ----------------------------------------------------------------------------
module pli_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dy,
    input  logic signed [32:0] i_dx,
    output logic               o_done,
    output logic signed [31:0] o_k
);

    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_fin;
    logic [CW-1:0]     r_cnt;
    logic [33:0]       r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [32:0]       r_den;
    logic              r_neg;

    logic [32:0] mag_dy;
    logic [32:0] mag_dx;
    logic [33:0] trial;
    logic        fits;

    assign mag_dy = i_dy[32] ? 33'(-i_dy) : 33'(i_dy);
    assign mag_dx = i_dx[32] ? 33'(-i_dx) : 33'(i_dx);
    assign trial  = {r_rem[32:0], r_quo[NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(NUM_W - 1))) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= NUM_W'(mag_dy) << FRAC_BITS;
            r_den <= mag_dx;
            r_neg <= i_dy[32] ^ i_dx[32];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    // quotient magnitude to signed 32 bits with saturation
    always_comb begin
        if (r_neg) begin
            o_k = (r_quo > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(r_quo[31:0]);
        end else begin
            o_k = (r_quo > NUM_W'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(r_quo[31:0]);
        end
    end

    assign o_done = r_fin;

endmodule
